[design/bpfl_pkg.sv]
// Shared types and constants for the buffer pool free list.
package bpfl_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned CntW       = 7;

  typedef enum logic {
    FuncAlloc   = 1'b0,
    FuncRelease = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StEmpty  = 2'd1,
    StDouble = 2'd2,
    StRange  = 2'd3
  } status_e;

  typedef enum logic {
    SIdle = 1'b0,
    SExec = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

[design/bpfl_req_if.sv]
// Request channel: allocate or release transactions.
interface bpfl_req_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [bpfl_pkg::IdxW-1:0]       release_index;

  modport source (output valid, func, release_index, input ready);
  modport sink   (input valid, func, release_index, output ready);
endinterface

[design/bpfl_rsp_if.sv]
// Response channel: one result per request.
interface bpfl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [bpfl_pkg::IdxW-1:0]       granted_index;
  logic [1:0]                      status;
  logic [bpfl_pkg::CntW-1:0]       free_count;

  modport source (output valid, granted_index, status, free_count, input ready);
  modport sink   (input valid, granted_index, status, free_count, output ready);
endinterface

[design/bpfl_cfg_if.sv]
// Configuration write channel for the entries-in-use register.
interface bpfl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpfl_pkg::CntW-1:0]       data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[design/bpfl_ctrl.sv]
// Control state machine: request acceptance, commit and response valid.
module bpfl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output bpfl_pkg::dp_cmd_t cmd_o
);

  bpfl_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpfl_pkg::SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      bpfl_pkg::SIdle: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) begin
          state_d = bpfl_pkg::SExec;
        end
      end
      bpfl_pkg::SExec: begin
        // result register must be free or draining this cycle
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = bpfl_pkg::SIdle;
        end
      end
      default: state_d = bpfl_pkg::SIdle;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = out_valid_q;

  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpfl_pkg::SExec |-> !req_ready_o)
    else $error("request accepted while one is in flight");

  a_commit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> rsp_valid_o)
    else $error("commit did not present a response");

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == bpfl_pkg::SExec)
    else $error("captured request not executed");

endmodule

[design/bpfl_dp.sv]
// Datapath: free-index queue memory, entry flags, counters and result register.
module bpfl_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpfl_pkg::dp_cmd_t         cmd_i,
  input  logic                      func_i,
  input  logic [bpfl_pkg::IdxW-1:0] release_index_i,
  input  logic                      cfg_we_i,
  input  logic [bpfl_pkg::CntW-1:0] cfg_data_i,
  output logic [bpfl_pkg::IdxW-1:0] granted_index_o,
  output logic [1:0]                status_o,
  output logic [bpfl_pkg::CntW-1:0] free_count_o
);

  localparam logic [bpfl_pkg::CntW-1:0] MaxCnt = bpfl_pkg::CntW'(bpfl_pkg::MaxEntries);

  logic [bpfl_pkg::IdxW-1:0] mem_q [bpfl_pkg::MaxEntries];
  logic [bpfl_pkg::IdxW-1:0] rd_q;

  logic [bpfl_pkg::CntW-1:0] entries_q, entries_d;
  logic [bpfl_pkg::IdxW-1:0] head_q, head_d;
  logic [bpfl_pkg::IdxW-1:0] tail_q, tail_d;
  logic [bpfl_pkg::CntW-1:0] count_q, count_d;
  logic [bpfl_pkg::CntW-1:0] wcount_q, wcount_d;   // queue writes since fill, saturating
  logic [bpfl_pkg::MaxEntries-1:0] free_q, free_d;

  logic                      func_q;
  logic [bpfl_pkg::IdxW-1:0] idx_q;

  logic [bpfl_pkg::IdxW-1:0] gnt_q, gnt_d;
  bpfl_pkg::status_e         st_q, st_d;
  logic [bpfl_pkg::CntW-1:0] fc_q;

  logic                      mem_we;
  logic [bpfl_pkg::IdxW-1:0] head_ofs;
  logic                      head_written;
  logic [bpfl_pkg::IdxW-1:0] head_val;
  logic [bpfl_pkg::CntW-1:0] cfg_sat;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      idx_q  <= release_index_i;
    end
  end

  // queue memory, registered read at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= idx_q;
    end
    rd_q <= mem_q[head_q];
  end

  // A slot not written since the last fill still holds its own index.
  assign head_ofs     = head_q - entries_q[bpfl_pkg::IdxW-1:0];
  assign head_written = wcount_q > {1'b0, head_ofs};
  assign head_val     = head_written ? rd_q : head_q;
  assign cfg_sat      = (cfg_data_i > MaxCnt) ? MaxCnt : cfg_data_i;

  always_comb begin
    entries_d = entries_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    wcount_d  = wcount_q;
    free_d    = free_q;
    gnt_d     = '0;
    st_d      = bpfl_pkg::StOk;
    mem_we    = 1'b0;

    if (cfg_we_i) begin
      entries_d = cfg_sat;
      head_d    = '0;
      tail_d    = cfg_sat[bpfl_pkg::IdxW-1:0];
      count_d   = cfg_sat;
      wcount_d  = '0;
      free_d    = '1;
    end else if (cmd_i.commit) begin
      if (func_q == bpfl_pkg::FuncAlloc) begin
        if (count_q == '0) begin
          st_d = bpfl_pkg::StEmpty;
        end else begin
          gnt_d            = head_val;
          head_d           = head_q + 1'b1;
          count_d          = count_q - 1'b1;
          free_d[head_val] = 1'b0;
        end
      end else begin
        if ({1'b0, idx_q} >= entries_q) begin
          st_d = bpfl_pkg::StRange;
        end else if (free_q[idx_q]) begin
          st_d = bpfl_pkg::StDouble;
        end else begin
          free_d[idx_q] = 1'b1;
          mem_we        = 1'b1;
          tail_d        = tail_q + 1'b1;
          count_d       = count_q + 1'b1;
          if (wcount_q != MaxCnt) begin
            wcount_d = wcount_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= MaxCnt;
      head_q    <= '0;
      tail_q    <= MaxCnt[bpfl_pkg::IdxW-1:0];
      count_q   <= MaxCnt;
      wcount_q  <= '0;
      free_q    <= '1;
    end else begin
      entries_q <= entries_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      wcount_q  <= wcount_d;
      free_q    <= free_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      gnt_q <= gnt_d;
      st_q  <= st_d;
      fc_q  <= count_d;
    end
  end

  assign granted_index_o = gnt_q;
  assign status_o        = st_q;
  assign free_count_o    = fc_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= entries_q)
    else $error("free count exceeds entries in use");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q - head_q) == count_q[bpfl_pkg::IdxW-1:0])
    else $error("head, tail and count disagree");

  a_hold_when_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit && !cfg_we_i |=> $stable(count_q) && $stable(head_q) && $stable(tail_q)
                                   && $stable(free_q))
    else $error("pool state changed without a transaction");

  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !cfg_we_i && st_d != bpfl_pkg::StOk |=> $stable(count_q) && $stable(free_q))
    else $error("failed request modified the pool");

endmodule

[design/buffer_pool_free_list.sv]
// Top level of the buffer pool free list.
// Hands out and takes back buffer indices from a pool of up to 64 equal buffers. Each request
// (allocate or release) gives exactly one response with the granted index, a status code and
// the free count after the operation. A request is accepted in the idle state and committed to
// the result register in the execute state once that is free or draining, with none accepted in
// between. The free-index queue is a memory with one write and one read port whose registered
// read data gives the head entry when executing. A new request is taken while the previous
// response still waits to be accepted. Writing entries_in_use (values above 64 saturate) frees
// all buffers and requeues them in ascending order at once; slots not yet rewritten since then
// are tracked by a write count, so there is no clearing pass after reset or a write. The
// configuration channel is always ready and must only be written while no request is in flight.
module buffer_pool_free_list (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpfl_req_if.sink   req_i,
  bpfl_rsp_if.source rsp_o,
  bpfl_cfg_if.sink   cfg_i
);

  bpfl_pkg::dp_cmd_t cmd;
  logic              cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  bpfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  bpfl_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (req_i.func),
    .release_index_i (req_i.release_index),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_i.data),
    .granted_index_o (rsp_o.granted_index),
    .status_o        (rsp_o.status),
    .free_count_o    (rsp_o.free_count)
  );

endmodule

[dv/buffer_pool_free_list_test.sv]
// Self-checking testbench for the buffer pool free list: directed cases, then random traffic.
module buffer_pool_free_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned MaxEntries = bpfl_pkg::MaxEntries;
  localparam int unsigned IdxW       = bpfl_pkg::IdxW;
  localparam int unsigned CntW       = bpfl_pkg::CntW;

  typedef struct {
    logic [IdxW-1:0]   granted;
    bpfl_pkg::status_e status;
    logic [CntW-1:0]   free_count;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpfl_req_if req ();
  bpfl_rsp_if rsp ();
  bpfl_cfg_if cfg ();

  buffer_pool_free_list uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  always #10 clk = ~clk;

  // Pool model
  int unsigned     pool_size;
  logic [IdxW-1:0] free_fifo [MaxEntries];
  int unsigned     fifo_head, fifo_tail, fifo_count;
  bit              entry_free [MaxEntries];
  pool_result_t    pending_results [$];

  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;
  int unsigned ready_pct = 100;
  int unsigned n_alloc = 0;
  int unsigned n_release = 0;
  int unsigned n_sizes = 0;
  int unsigned n_status [4] = '{0, 0, 0, 0};

  function automatic void pool_reinit(int unsigned n);
    if (n > MaxEntries) n = MaxEntries;
    pool_size = n;
    for (int i = 0; i < MaxEntries; i++) begin
      entry_free[i] = 1'b1;
      free_fifo[i]  = (i < n) ? IdxW'(i) : '0;
    end
    fifo_head  = 0;
    fifo_tail  = n % MaxEntries;
    fifo_count = n;
  endfunction

  function automatic void predict_request(bpfl_pkg::func_e f, logic [IdxW-1:0] idx);
    pool_result_t r;
    r.granted = '0;
    r.status  = bpfl_pkg::StOk;
    if (f == bpfl_pkg::FuncAlloc) begin
      n_alloc++;
      if (fifo_count == 0) begin
        r.status = bpfl_pkg::StEmpty;
      end else begin
        r.granted = free_fifo[fifo_head];
        fifo_head = (fifo_head + 1) % MaxEntries;
        fifo_count--;
        entry_free[r.granted] = 1'b0;
      end
    end else begin
      n_release++;
      // range is checked ahead of the double-release check
      if (idx >= pool_size) begin
        r.status = bpfl_pkg::StRange;
      end else if (entry_free[idx]) begin
        r.status = bpfl_pkg::StDouble;
      end else begin
        entry_free[idx]      = 1'b1;
        free_fifo[fifo_tail] = idx;
        fifo_tail = (fifo_tail + 1) % MaxEntries;
        fifo_count++;
      end
    end
    r.free_count = CntW'(fifo_count);
    n_status[r.status]++;
    pending_results.push_back(r);
  endfunction

  // Track accepted transactions and check responses
  always @(posedge clk) begin
    pool_result_t want;
    if (cfg.valid && cfg.ready) pool_reinit(cfg.data);
    if (req.valid && req.ready)
      predict_request(bpfl_pkg::func_e'(req.func), req.release_index);
    if (rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected response: index %0d status %0d free %0d",
                   rsp.granted_index, rsp.status, rsp.free_count);
      end else begin
        want = pending_results.pop_front();
        if (rsp.granted_index !== want.granted || rsp.status !== want.status ||
            rsp.free_count !== want.free_count) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"mismatch: expected index %0d status %0d free %0d, ",
                      "got index %0d status %0d free %0d"},
                     want.granted, want.status, want.free_count,
                     rsp.granted_index, rsp.status, rsp.free_count);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99, 0) < ready_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input bpfl_pkg::func_e f, input logic [IdxW-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
    req.valid         <= 1'b1;
    req.func          <= f;
    req.release_index <= idx;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_pool_size(input logic [CntW-1:0] n);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.data  <= n;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    n_sizes++;
  endtask

  task automatic test_reset_pool();
    gap_max   = 0;
    ready_pct = 100;
    send_request(bpfl_pkg::FuncAlloc, '0);
    send_request(bpfl_pkg::FuncAlloc, '1);
    send_request(bpfl_pkg::FuncRelease, 6'd0);
    send_request(bpfl_pkg::FuncRelease, 6'd0);
    send_request(bpfl_pkg::FuncRelease, 6'd63);
    send_request(bpfl_pkg::FuncAlloc, '0);
  endtask

  task automatic test_saturated_size();
    write_pool_size(7'd127);
    send_request(bpfl_pkg::FuncAlloc, '1);
    send_request(bpfl_pkg::FuncRelease, 6'd63);
    send_request(bpfl_pkg::FuncRelease, 6'd0);
  endtask

  task automatic test_empty_pool();
    write_pool_size(7'd0);
    send_request(bpfl_pkg::FuncAlloc, '0);
    send_request(bpfl_pkg::FuncRelease, 6'd0);
    send_request(bpfl_pkg::FuncRelease, 6'd63);
  endtask

  task automatic test_single_entry();
    write_pool_size(7'd1);
    ready_pct = 50;
    send_request(bpfl_pkg::FuncAlloc, '0);
    send_request(bpfl_pkg::FuncAlloc, '0);
    send_request(bpfl_pkg::FuncRelease, 6'd1);
    send_request(bpfl_pkg::FuncRelease, 6'd0);
    send_request(bpfl_pkg::FuncRelease, 6'd0);
    send_request(bpfl_pkg::FuncAlloc, '0);
  endtask

  // Drifts between draining and refilling the pool so empty and full both occur
  task automatic run_random_phase(input int unsigned size, input int unsigned items,
                                  input int unsigned gmax, input int unsigned rpct);
    bit               allocating;
    int unsigned      busy [$];
    bpfl_pkg::func_e  f;
    logic [IdxW-1:0]  idx;
    write_pool_size(CntW'(size));
    gap_max    = gmax;
    ready_pct  = rpct;
    allocating = 1'b1;
    repeat (items) begin
      if (fifo_count == 0) allocating = 1'b0;
      else if (fifo_count == pool_size) allocating = 1'b1;
      else if ($urandom_range(39, 0) == 0) allocating = !allocating;
      busy.delete();
      for (int i = 0; i < pool_size; i++)
        if (!entry_free[i]) busy.push_back(i);
      if ($urandom_range(99, 0) < (allocating ? 80 : 20)) begin
        f   = bpfl_pkg::FuncAlloc;
        idx = IdxW'($urandom);
      end else begin
        f = bpfl_pkg::FuncRelease;
        if (busy.size() != 0 && $urandom_range(99, 0) < 85)
          idx = IdxW'(busy[$urandom_range(busy.size() - 1, 0)]);
        else
          idx = IdxW'($urandom);
      end
      send_request(f, idx);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(64, 120, 0, 100);
    run_random_phase(5, 120, 4, 60);
    run_random_phase(127, 120, 2, 85);
    run_random_phase(1, 60, 6, 40);
    run_random_phase(33, 120, 0, 100);
    run_random_phase(0, 20, 3, 70);
    run_random_phase(17, 120, 10, 30);
    run_random_phase(64, 120, 1, 90);
    run_random_phase(2, 60, 2, 75);
  endtask

  initial begin
    req.valid         = 1'b0;
    req.func          = 1'b0;
    req.release_index = '0;
    rsp.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.data          = '0;
    pool_reinit(MaxEntries);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_pool();
    test_saturated_size();
    test_empty_pool();
    test_single_entry();
    test_random_traffic();

    wait_idle();
    repeat (4) @(negedge clk);
    $display("covered %0d requests (%0d allocate, %0d release) over %0d pool size writes",
             n_alloc + n_release, n_alloc, n_release, n_sizes);
    $display("outcomes: %0d ok, %0d pool empty, %0d double release, %0d out of range",
             n_status[bpfl_pkg::StOk], n_status[bpfl_pkg::StEmpty],
             n_status[bpfl_pkg::StDouble], n_status[bpfl_pkg::StRange]);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
design/bpfl_pkg.sv
design/bpfl_req_if.sv
design/bpfl_rsp_if.sv
design/bpfl_cfg_if.sv
design/bpfl_ctrl.sv
design/bpfl_dp.sv
design/buffer_pool_free_list.sv
dv/buffer_pool_free_list_test.sv
